[rtl/dts_pkg.sv]
// Package: shared types and constants for the topological sort block.
`timescale 1ns / 1ps
`default_nettype none
package dts_pkg;
  localparam int unsigned MaxVertices = 64;
  localparam int unsigned VcountW = 7;
  localparam int unsigned EcountW = 11;
  localparam int unsigned CfgDataW = 11;
  localparam int unsigned LoadedW = 12;
  localparam logic [LoadedW-1:0] LoadedMax = 12'd4095;

  typedef enum logic [0:0] {
    CfgVertexCount = 1'b0,
    CfgEdgeCount   = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    OpAddEdge = 1'b0,
    OpSort    = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StTooMany   = 3'd1,
    StBadVertex = 3'd2,
    StMissing   = 3'd3,
    StCycle     = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    SIdle, SClear, SCheck, SRoot, SRootRd, STopRd, SScan, SNbrRd, SEmit, SErr
  } state_e;

  typedef struct packed {
    logic [0:0] operation;
    logic [6:0] edge_from;
    logic [6:0] edge_to;
  } in_item_t;

  typedef struct packed {
    logic [6:0] vertex_out;
    logic [2:0] status;
    logic       last;
  } out_item_t;
endpackage
`default_nettype wire

[rtl/dfs_topological_sort.sv]
// Top level: edge loader and sequenced depth-first topological sort.
//
// An edge item (operation 0) is taken without raising busy, and the next item may
// follow in the next cycle. A sort item raises busy from its accepting edge until the
// clearing pass after its results has ended. Results come one per cycle with done_o
// high; the receiver cannot stall them. A sort first checks the counts. Count errors
// skip the walk and give their single result in the next cycle; a cycle found in
// the walk also gives a single error result. The walk uses registered reads of the
// adjacency, mark and stack memories: each root is tested by reading its mark, and
// opening a tree reads the stack top and its adjacency row; each set adjacency bit
// is found and then its mark is read, and a white vertex is pushed; each finished
// vertex is written to the finish order, and the vertex below it on the stack is
// reloaded; the end of the root scan starts the results, one per cycle. After the
// results, a clearing pass resets the adjacency rows and marks, one row per cycle,
// with busy high; the same pass runs after reset, so busy is high until it ends.
`timescale 1ns / 1ps
`default_nettype none
module dfs_topological_sort #(
  parameter int unsigned MAX_VERTICES = dts_pkg::MaxVertices
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start,
  output logic                           busy,
  input  wire dts_pkg::in_item_t         item_i,
  output logic                           done_o,
  output dts_pkg::out_item_t             result_o,
  input  wire                            cfg_we_i,
  input  wire  [0:0]                     cfg_idx_i,
  input  wire  [dts_pkg::CfgDataW-1:0]   cfg_data_i
);
  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned SW = AW + 1;

  logic [dts_pkg::VcountW-1:0] vcount_q;
  logic [dts_pkg::EcountW-1:0] ecount_q;
  logic [dts_pkg::LoadedW-1:0] loaded_q;
  logic bad_q;

  // memories
  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [1:0]              mark_mem [MAX_VERTICES];
  logic [AW+SW-1:0]        stk_mem [MAX_VERTICES];
  logic [AW-1:0]           fin_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_rd_q;
  logic [1:0]              mark_rd_q;
  logic [AW+SW-1:0]        stk_rd_q;
  logic [AW-1:0]           fin_rd_q;

  dts_pkg::state_e state_q, state_d;
  logic [SW-1:0] nv;
  logic [SW-1:0] root_q, root_d;
  logic [SW-1:0] sp_q, sp_d;
  logic [SW-1:0] nfin_q, nfin_d;
  logic [SW-1:0] idx_q, idx_d;
  logic [AW-1:0] cur_v_q, cur_v_d;
  logic [SW-1:0] cur_n_q, cur_n_d;
  logic [2:0]    err_q, err_d;

  assign nv = (vcount_q > dts_pkg::VcountW'(MAX_VERTICES)) ? SW'(MAX_VERTICES)
                                                          : SW'(vcount_q);

  // first set neighbor at or above cur_n below nv
  logic          nb_found;
  logic [AW-1:0] nb_idx;
  always_comb begin
    nb_found = 1'b0;
    nb_idx = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (adj_rd_q[i] && (SW'(i) >= cur_n_q) && (SW'(i) < nv)) begin
        nb_found = 1'b1;
        nb_idx = AW'(i);
      end
    end
  end

  logic accept;
  assign accept = start && !busy;
  logic fe_ok;
  assign fe_ok = (item_i.edge_from != '0) && ({1'b0, item_i.edge_from} <= {1'b0, SW'(nv)}) &&
                 (item_i.edge_to != '0) && ({1'b0, item_i.edge_to} <= {1'b0, SW'(nv)});

  logic [13:0] maxe;
  assign maxe = (14'(nv) * 14'(nv - ((nv != '0) ? SW'(1) : SW'(0)))) >> 1;

  // memory control
  logic          adj_re, adj_we, mark_we, mark_re, stk_we, stk_re, fin_we, fin_re;
  logic [AW-1:0] adj_ra, adj_wa, mark_a, mark_ra, stk_a, stk_ra, fin_a, fin_ra;
  logic [MAX_VERTICES-1:0] adj_wd;
  logic [1:0]    mark_wd;
  logic [AW+SW-1:0] stk_wd;
  logic          edge_in;
  logic [AW-1:0] ef, et;
  assign ef = AW'(item_i.edge_from - 7'd1);
  assign et = AW'(item_i.edge_to - 7'd1);
  assign edge_in = accept && (item_i.operation == dts_pkg::OpAddEdge);

  // read-modify-write of adjacency for edge load, pipelined one stage
  logic          ld_pend_q;
  logic [AW-1:0] ld_row_q;
  logic [AW-1:0] ld_col_q;
  logic [MAX_VERTICES-1:0] ld_fwd;

  always_comb begin
    state_d = state_q;
    root_d = root_q; sp_d = sp_q; nfin_d = nfin_q; idx_d = idx_q;
    cur_v_d = cur_v_q; cur_n_d = cur_n_q; err_d = err_q;
    unique case (state_q)
      dts_pkg::SIdle: begin
        if (accept && item_i.operation == dts_pkg::OpSort) state_d = dts_pkg::SCheck;
      end
      dts_pkg::SCheck: begin
        root_d = '0; sp_d = '0; nfin_d = '0;
        priority if ({3'b0, ecount_q} > maxe) err_d = dts_pkg::StTooMany;
        else if (bad_q) err_d = dts_pkg::StBadVertex;
        else if ({1'b0, ecount_q} > loaded_q) err_d = dts_pkg::StMissing;
        else err_d = dts_pkg::StOk;
        if (({3'b0, ecount_q} > maxe) || bad_q || ({1'b0, ecount_q} > loaded_q))
          state_d = dts_pkg::SErr;
        else state_d = dts_pkg::SRoot;
      end
      dts_pkg::SRoot: begin
        if (root_q >= nv) begin
          idx_d = nfin_q;
          state_d = dts_pkg::SEmit;
        end else state_d = dts_pkg::SRootRd;
      end
      dts_pkg::SRootRd: begin
        if (mark_rd_q != 2'd0) begin
          root_d = root_q + SW'(1);
          state_d = dts_pkg::SRoot;
        end else begin
          sp_d = SW'(1);
          state_d = dts_pkg::STopRd;
        end
      end
      dts_pkg::STopRd: begin
        state_d = dts_pkg::SScan;
      end
      dts_pkg::SScan: begin
        // stack entry now valid; the adjacency row of its vertex is read here
        cur_v_d = stk_rd_q[AW-1:0];
        cur_n_d = stk_rd_q[AW+SW-1:AW];
        state_d = dts_pkg::SNbrRd;
      end
      dts_pkg::SNbrRd: begin
        // adj_rd_q holds row cur_v; mark_rd_q is of the found neighbor once nb_wait_q is set
        state_d = dts_pkg::SNbrRd;
        if (!nb_found) begin
          nfin_d = nfin_q + SW'(1);
          sp_d = sp_q - SW'(1);
          if (sp_q == SW'(1)) begin
            root_d = root_q + SW'(1);
            state_d = dts_pkg::SRoot;
          end else state_d = dts_pkg::STopRd;
        end else begin
          state_d = dts_pkg::STopRd;
          idx_d = idx_q;
        end
      end
      dts_pkg::SEmit: begin
        if (idx_q == '0) begin
          idx_d = '0;
          state_d = dts_pkg::SClear;
        end else if (idx_q == SW'(1)) begin
          idx_d = '0;
          state_d = dts_pkg::SClear;
        end else idx_d = idx_q - SW'(1);
      end
      dts_pkg::SErr: begin
        idx_d = '0;
        state_d = dts_pkg::SClear;
      end
      dts_pkg::SClear: begin
        idx_d = idx_q + SW'(1);
        if (idx_q == SW'(MAX_VERTICES - 1)) state_d = dts_pkg::SIdle;
      end
      default: state_d = dts_pkg::SIdle;
    endcase
  end

  // The neighbor check needs the neighbor's mark, so SNbrRd waits with nb_wait_q set.
  logic          nb_wait_q;
  logic [AW-1:0] nb_q;
  logic          cyc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dts_pkg::SClear;
      root_q <= '0; sp_q <= '0; nfin_q <= '0; idx_q <= '0;
      cur_v_q <= '0; cur_n_q <= '0; err_q <= '0;
      vcount_q <= '0; ecount_q <= '0; loaded_q <= '0; bad_q <= 1'b0;
      ld_pend_q <= 1'b0; nb_wait_q <= 1'b0; cyc_q <= 1'b0;
    end else begin
      ld_pend_q <= edge_in && fe_ok;
      if (cfg_we_i) begin
        if (cfg_idx_i == dts_pkg::CfgVertexCount) vcount_q <= cfg_data_i[6:0];
        else ecount_q <= cfg_data_i;
      end
      if (edge_in) begin
        if (loaded_q != dts_pkg::LoadedMax) loaded_q <= loaded_q + 12'd1;
        if (!fe_ok) bad_q <= 1'b1;
      end
      if (state_q == dts_pkg::SNbrRd && nb_found && !nb_wait_q) begin
        // hold state while the neighbor's mark is read
        nb_wait_q <= 1'b1;
        nb_q <= nb_idx;
        state_q <= dts_pkg::SNbrRd;
      end else if (state_q == dts_pkg::SNbrRd && nb_wait_q) begin
        nb_wait_q <= 1'b0;
        cur_n_q <= {1'b0, nb_q} + SW'(1);
        if (mark_rd_q == 2'd1) begin
          err_q <= dts_pkg::StCycle;
          state_q <= dts_pkg::SErr;
        end else if (mark_rd_q == 2'd0) begin
          sp_q <= sp_q + SW'(1);
          state_q <= dts_pkg::STopRd;
        end else state_q <= dts_pkg::SNbrRd;
      end else begin
        state_q <= state_d;
        root_q <= root_d; sp_q <= sp_d; nfin_q <= nfin_d; idx_q <= idx_d;
        cur_v_q <= cur_v_d; cur_n_q <= cur_n_d; err_q <= err_d;
        if (state_q == dts_pkg::SClear && state_d == dts_pkg::SIdle) begin
          loaded_q <= '0; bad_q <= 1'b0;
        end
      end
      cyc_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    ld_row_q <= ef;
    ld_col_q <= et;
  end

  // adjacency: single write, single read
  always_comb begin
    adj_we = 1'b0; adj_wa = '0; adj_wd = '0;
    adj_re = 1'b0; adj_ra = '0;
    ld_fwd = '0;
    ld_fwd[ld_col_q] = 1'b1;
    if (state_q == dts_pkg::SClear) begin
      adj_we = 1'b1; adj_wa = idx_q[AW-1:0]; adj_wd = '0;
    end else if (ld_pend_q) begin
      adj_we = 1'b1; adj_wa = ld_row_q; adj_wd = adj_rd_q | ld_fwd;
    end
    if (edge_in) begin
      adj_re = 1'b1; adj_ra = ef;
    end else if (state_q == dts_pkg::STopRd || state_q == dts_pkg::SScan) begin
      adj_re = 1'b1; adj_ra = (state_q == dts_pkg::STopRd) ? stk_ra : cur_v_d;
    end
  end

  // forward a pending write to a back-to-back read of the same row
  logic fwd_q;
  logic [MAX_VERTICES-1:0] fwd_data_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fwd_q <= 1'b0;
    else fwd_q <= adj_re && adj_we && (adj_ra == adj_wa);
  end
  logic [MAX_VERTICES-1:0] adj_raw_q;
  always_ff @(posedge clk_i) begin
    fwd_data_q <= adj_wd;
    if (adj_we) adj_mem[adj_wa] <= adj_wd;
    if (adj_re) adj_raw_q <= adj_mem[adj_ra];
  end
  assign adj_rd_q = fwd_q ? fwd_data_q : adj_raw_q;

  // marks
  always_comb begin
    mark_we = 1'b0; mark_a = '0; mark_wd = 2'd0;
    mark_re = 1'b0; mark_ra = '0;
    priority if (state_q == dts_pkg::SClear) begin
      mark_we = 1'b1; mark_a = idx_q[AW-1:0];
    end else if (state_q == dts_pkg::SRootRd && mark_rd_q == 2'd0) begin
      mark_we = 1'b1; mark_a = root_q[AW-1:0]; mark_wd = 2'd1;
    end else if (state_q == dts_pkg::SNbrRd && nb_wait_q && mark_rd_q == 2'd0) begin
      mark_we = 1'b1; mark_a = nb_q; mark_wd = 2'd1;
    end else if (state_q == dts_pkg::SNbrRd && !nb_wait_q && !nb_found) begin
      mark_we = 1'b1; mark_a = cur_v_q; mark_wd = 2'd2;
    end
    if (state_q == dts_pkg::SRoot) begin
      mark_re = 1'b1; mark_ra = root_q[AW-1:0];
    end else if (state_q == dts_pkg::SNbrRd && !nb_wait_q) begin
      mark_re = 1'b1; mark_ra = nb_idx;
    end
  end
  always_ff @(posedge clk_i) begin
    if (mark_we) mark_mem[mark_a] <= mark_wd;
    if (mark_re) mark_rd_q <= mark_mem[mark_ra];
  end

  // walk stack
  always_comb begin
    stk_we = 1'b0; stk_a = '0; stk_wd = '0;
    stk_re = 1'b0;
    stk_ra = AW'(sp_q - SW'(1));
    if (state_q == dts_pkg::SRootRd && mark_rd_q == 2'd0) begin
      stk_we = 1'b1; stk_a = '0; stk_wd = {SW'(0), root_q[AW-1:0]};
    end else if (state_q == dts_pkg::SNbrRd && nb_wait_q) begin
      // save the resume point of the current top, push if white
      stk_we = 1'b1; stk_a = AW'(sp_q - SW'(1));
      stk_wd = {SW'({1'b0, nb_q} + SW'(1)), cur_v_q};
    end
    if (state_q == dts_pkg::STopRd) stk_re = 1'b1;
  end
  logic          push_q;
  logic [AW-1:0] push_a_q, push_v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) push_q <= 1'b0;
    else push_q <= state_q == dts_pkg::SNbrRd && nb_wait_q && mark_rd_q == 2'd0;
  end
  always_ff @(posedge clk_i) begin
    push_a_q <= AW'(sp_q);
    push_v_q <= nb_q;
    if (stk_we) stk_mem[stk_a] <= stk_wd;
    else if (push_q) stk_mem[push_a_q] <= {SW'(0), push_v_q};
  end
  // pushed entry is read in STopRd right after push_q: forward it
  logic stk_fwd_q;
  logic [AW+SW-1:0] stk_fwd_d_q, stk_raw_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) stk_fwd_q <= 1'b0;
    else stk_fwd_q <= stk_re && ((stk_we && stk_a == stk_ra) ||
                                 (!stk_we && push_q && push_a_q == stk_ra));
  end
  always_ff @(posedge clk_i) begin
    stk_fwd_d_q <= stk_we ? stk_wd : {SW'(0), push_v_q};
    if (stk_re) stk_raw_q <= stk_mem[stk_ra];
  end
  assign stk_rd_q = stk_fwd_q ? stk_fwd_d_q : stk_raw_q;

  // finish order
  always_comb begin
    fin_we = state_q == dts_pkg::SNbrRd && !nb_wait_q && !nb_found;
    fin_a = nfin_q[AW-1:0];
    fin_re = state_q == dts_pkg::SRoot && root_q >= nv;
    fin_ra = AW'(nfin_q - SW'(1));
    if (state_q == dts_pkg::SEmit) begin
      fin_re = 1'b1; fin_ra = AW'(idx_q - SW'(2));
    end
  end
  always_ff @(posedge clk_i) begin
    if (fin_we) fin_mem[fin_a] <= cur_v_q;
    if (fin_re) fin_rd_q <= fin_mem[fin_ra];
  end

  always_comb begin
    done_o = 1'b0;
    result_o = '0;
    if (state_q == dts_pkg::SErr) begin
      done_o = 1'b1;
      result_o.status = err_q;
      result_o.last = 1'b1;
    end else if (state_q == dts_pkg::SEmit) begin
      done_o = 1'b1;
      result_o.last = (idx_q <= SW'(1));
      result_o.vertex_out = (idx_q == '0) ? 7'd0 : 7'({1'b0, fin_rd_q} + 7'd1);
    end
  end

  assign busy = (state_q != dts_pkg::SIdle) || cyc_q;
endmodule
`default_nettype wire

[rtl/dts_checker.sv]
// Checker: port-level properties of the topological sort block, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
module dts_checker (
  input wire                     clk_i,
  input wire                     rst_ni,
  input wire                     busy,
  input wire                     done_o,
  input wire dts_pkg::out_item_t result_o
);
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result outside a sort");
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.status != dts_pkg::StOk |-> result_o.last && result_o.vertex_out == '0)
    else $error("error result malformed");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.last |=> !done_o) else $error("result after last");
  a_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !result_o.last |=> done_o) else $error("gap in result burst");
endmodule
bind dfs_topological_sort dts_checker u_dts_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .busy(busy),
  .done_o(done_o), .result_o(result_o)
);
`default_nettype wire

[bench/tb_checker.sv]
// Checker: watches the sort channels, predicts the vertex order and compares results.
`timescale 1ns / 1ps
module tb_checker (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    start_i,
  input  wire                    busy_i,
  input  wire dts_pkg::in_item_t item_i,
  input  wire                    done_i,
  input  wire dts_pkg::out_item_t result_i,
  input  wire                    cfg_we_i,
  input  wire [0:0]              cfg_idx_i,
  input  wire [dts_pkg::CfgDataW-1:0] cfg_data_i,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     sorts_o,
  output int                     results_o
);
  logic [63:0] adj_rows [64];
  logic [1:0]  mark [64];
  logic [11:0] edges_seen;
  logic        bad_seen;
  logic [6:0]  vcount;
  logic [10:0] ecount;
  dts_pkg::out_item_t order_q [$];

  task automatic wipe_graph();
    for (int i = 0; i < 64; i++) begin
      adj_rows[i] = '0;
      mark[i] = 2'd0;
    end
    edges_seen = '0;
    bad_seen = 1'b0;
  endtask

  // Depth-first walk; returns -1 on a grey vertex, else the finish count.
  function automatic int walk_graph(int nv, ref logic [5:0] fin [64]);
    int stk_v [64];
    int stk_n [64];
    int sp, nf, v, n;
    nf = 0;
    for (int r = 0; r < nv; r++) begin
      if (mark[r] != 2'd0) continue;
      mark[r] = 2'd1;
      stk_v[0] = r; stk_n[0] = 0; sp = 1;
      while (sp > 0) begin
        v = stk_v[sp-1];
        n = stk_n[sp-1];
        while (n < nv && !adj_rows[v][n]) n++;
        if (n < nv) begin
          stk_n[sp-1] = n + 1;
          if (mark[n] == 2'd1) return -1;
          if (mark[n] == 2'd0 && sp < 64) begin
            mark[n] = 2'd1;
            stk_v[sp] = n; stk_n[sp] = 0; sp++;
          end
        end else begin
          mark[v] = 2'd2;
          if (nf < 64) begin
            fin[nf] = v[5:0];
            nf++;
          end
          sp--;
        end
      end
    end
    return nf;
  endfunction

  task automatic predict_sort();
    int nv, nf, maxe;
    logic [5:0] fin [64];
    dts_pkg::status_e st;
    dts_pkg::out_item_t r;
    nv = (vcount > 64) ? 64 : int'(vcount);
    maxe = nv * (nv > 0 ? nv - 1 : 0) / 2;
    st = dts_pkg::StOk;
    nf = 0;
    if (int'(ecount) > maxe) st = dts_pkg::StTooMany;
    else if (bad_seen) st = dts_pkg::StBadVertex;
    else if (edges_seen < {1'b0, ecount}) st = dts_pkg::StMissing;
    if (st == dts_pkg::StOk) begin
      nf = walk_graph(nv, fin);
      if (nf < 0) st = dts_pkg::StCycle;
    end
    if (st != dts_pkg::StOk || nf == 0) begin
      r.vertex_out = '0; r.status = st; r.last = 1'b1;
      order_q.push_back(r);
    end else begin
      for (int k = 0; k < nf; k++) begin
        r.vertex_out = 7'(fin[nf-1-k]) + 7'd1;
        r.status = dts_pkg::StOk;
        r.last = (k == nf - 1);
        order_q.push_back(r);
      end
    end
    wipe_graph();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    dts_pkg::out_item_t exp_r;
    if (!rst_ni) begin
      wipe_graph();
      vcount <= '0;
      ecount <= '0;
      order_q.delete();
      fail_count_o <= 0;
      pending_o <= 0;
      sorts_o <= 0;
      results_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == dts_pkg::CfgVertexCount) vcount <= cfg_data_i[6:0];
        else ecount <= cfg_data_i[10:0];
      end
      if (done_i) begin
        results_o <= results_o + 1;
        if (order_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10)
            $display("checker: unexpected result %p, none expected", result_i);
        end else begin
          exp_r = order_q.pop_front();
          if (exp_r !== result_i) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10)
              $display("checker: mismatch exp v=%0d s=%0d l=%0d got v=%0d s=%0d l=%0d",
                       exp_r.vertex_out, exp_r.status, exp_r.last,
                       result_i.vertex_out, result_i.status, result_i.last);
          end
        end
      end
      if (start_i && !busy_i) begin
        if (item_i.operation == dts_pkg::OpAddEdge) begin
          if (item_i.edge_from < 1 || item_i.edge_from > vcount || item_i.edge_from > 64 ||
              item_i.edge_to < 1 || item_i.edge_to > vcount || item_i.edge_to > 64)
            bad_seen = 1'b1;
          else
            adj_rows[item_i.edge_from-1][item_i.edge_to-1] = 1'b1;
          if (edges_seen < dts_pkg::LoadedMax) edges_seen = edges_seen + 1;
        end else begin
          sorts_o <= sorts_o + 1;
          predict_sort();
        end
      end
      pending_o <= order_q.size();
    end
  end
endmodule

[bench/tb_top.sv]
// Testbench top: drives edge loads, sorts and register writes, and reports the verdict.
`timescale 1ns / 1ps
module tb_top;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  dts_pkg::in_item_t item_i = '0;
  logic done_o;
  dts_pkg::out_item_t result_o;
  logic cfg_we_i = 1'b0;
  logic [0:0] cfg_idx_i = '0;
  logic [dts_pkg::CfgDataW-1:0] cfg_data_i = '0;
  int fail_count, pending, sorts, results;
  int idle_cycles;
  bit calm;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  dfs_topological_sort u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_i),
    .done_o(done_o), .result_o(result_o), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  tb_checker u_chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .busy_i(busy), .item_i(item_i),
    .done_i(done_o), .result_i(result_o), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .fail_count_o(fail_count), .pending_o(pending),
    .sorts_o(sorts), .results_o(results)
  );

  // Watchdog: count cycles with no accepted item, register write or result.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || cfg_we_i || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic send_item(dts_pkg::op_e op, logic [6:0] src, logic [6:0] dst);
    if (!calm && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= '{operation: op, edge_from: src, edge_to: dst};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (op == dts_pkg::OpSort) begin
      // drop start so the sort is not issued twice
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller drops it.
  task automatic write_cfg(dts_pkg::cfg_idx_e idx, int val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= dts_pkg::CfgDataW'(val);
    @(posedge clk_i);
  endtask

  task automatic set_graph(int nv, int ne);
    drain();
    write_cfg(dts_pkg::CfgVertexCount, nv);
    write_cfg(dts_pkg::CfgEdgeCount, ne);
    cfg_we_i <= 1'b0;
  endtask

  // Load a random DAG (edges go low to high under a shuffled labeling) or a random graph, then sort.
  task automatic random_graph(int nv, bit acyclic, int ne_decl);
    int perm [64];
    int tmp, j, a, b, ne;
    for (int i = 0; i < 64; i++) perm[i] = i + 1;
    for (int i = nv - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = perm[i]; perm[i] = perm[j]; perm[j] = tmp;
    end
    ne = ne_decl + $urandom_range(0, 3);
    for (int e = 0; e < ne; e++) begin
      a = $urandom_range(0, nv - 1);
      b = $urandom_range(0, nv - 1);
      if (acyclic) begin
        if (a == b) b = (a + 1) % nv;
        if (a > b) begin tmp = a; a = b; b = tmp; end
        send_item(dts_pkg::OpAddEdge, 7'(perm[a]), 7'(perm[b]));
      end else begin
        send_item(dts_pkg::OpAddEdge, 7'(perm[a]), 7'(perm[b]));
      end
    end
    send_item(dts_pkg::OpSort, 7'($urandom), 7'($urandom));
  endtask

  initial begin
    int nv, ne, kind;
    calm = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty graph, small cases (duplicate edge, cycles, bad and missing edges), then extremes of the registers
    send_item(dts_pkg::OpSort, 7'h7f, 7'h7f);
    set_graph(3, 2);
    send_item(dts_pkg::OpAddEdge, 7'd1, 7'd2);
    send_item(dts_pkg::OpAddEdge, 7'd2, 7'd3);
    send_item(dts_pkg::OpAddEdge, 7'd1, 7'd2);
    send_item(dts_pkg::OpSort, 7'd0, 7'd0);
    send_item(dts_pkg::OpAddEdge, 7'd3, 7'd1);
    send_item(dts_pkg::OpAddEdge, 7'd1, 7'd3);
    send_item(dts_pkg::OpAddEdge, 7'd3, 7'd1);
    send_item(dts_pkg::OpSort, 7'd0, 7'd0);
    send_item(dts_pkg::OpAddEdge, 7'd2, 7'd2);
    send_item(dts_pkg::OpAddEdge, 7'd1, 7'd3);
    send_item(dts_pkg::OpSort, 7'd0, 7'd0);
    send_item(dts_pkg::OpAddEdge, 7'd0, 7'd1);
    send_item(dts_pkg::OpAddEdge, 7'd1, 7'h7f);
    send_item(dts_pkg::OpSort, 7'd0, 7'd0);
    send_item(dts_pkg::OpAddEdge, 7'd1, 7'd2);
    send_item(dts_pkg::OpSort, 7'd0, 7'd0);
    set_graph(3, 4);
    send_item(dts_pkg::OpSort, 7'd0, 7'd0);
    set_graph(127, 2016);
    send_item(dts_pkg::OpAddEdge, 7'd64, 7'd1);
    send_item(dts_pkg::OpSort, 7'd0, 7'd0);
    set_graph(64, 0);
    send_item(dts_pkg::OpAddEdge, 7'd65, 7'd64);
    send_item(dts_pkg::OpSort, 7'd0, 7'd0);
    set_graph(64, 0);
    send_item(dts_pkg::OpSort, 7'd0, 7'd0);
    set_graph(0, 2047);
    send_item(dts_pkg::OpSort, 7'd0, 7'd0);

    // random phases: mostly acyclic loads, some cyclic or broken ones
    for (int ph = 0; ph < 34; ph++) begin
      if (ph >= 29) calm = 1'b1;
      kind = $urandom_range(0, 9);
      nv = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 70) : $urandom_range(1, 10);
      if (nv > 64) ne = 0; else ne = $urandom_range(0, nv * (nv - 1) / 2);
      if (ne > 12) ne = $urandom_range(0, 12);
      if (kind == 9) ne = $urandom_range(0, 2047);
      set_graph(nv, ne);
      for (int rep = 0; rep < 2; rep++) begin
        if (kind < 6) random_graph(nv > 64 ? 64 : nv, 1'b1, ne);
        else if (kind < 8) random_graph(nv > 64 ? 64 : nv, 1'b0, ne);
        else begin
          for (int e = 0; e < (ne > 12 ? 12 : ne); e++)
            send_item(dts_pkg::OpAddEdge, 7'($urandom), 7'($urandom));
          send_item(dts_pkg::OpSort, 7'($urandom), 7'($urandom));
        end
      end
    end

    drain();
    $display("tb_top: ran %0d sorts over random and directed graphs, %0d results checked",
             sorts, results);
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/dts_pkg.sv
rtl/dfs_topological_sort.sv
rtl/dts_checker.sv
bench/tb_checker.sv
bench/tb_top.sv
